>>> design/tts_pkg.sv
`default_nettype none
package tts_pkg;

    localparam int FUNC_W = 16;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 4;

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 96;

    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_DESTROY = 2'd2;

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_FIRE    = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_DESTROY = 2'd3;

    typedef struct packed {
        logic              busy;
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] arg;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] due;
    } t_slot;

endpackage
`default_nettype wire

>>> design/tts_cell.sv
`default_nettype none
module tts_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire tts_pkg::t_slot i_prev,
    input  wire logic          i_wr,
    input  wire tts_pkg::t_slot i_wdata,
    output tts_pkg::t_slot     o_slot
);

    tts_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_prev;
        end else if (i_wr) begin
            r_slot <= i_wdata;
        end
    end

    assign o_slot = r_slot;

endmodule
`default_nettype wire

>>> design/timed_task_slot_scheduler.sv
// Create and destroy: the result is registered and shows in the cycle after the item is accepted.
// Schedule tick: the slot ring rotates one cell per cycle through one update unit,
// except while the output is stalled; after every slot has passed, a summary is sent.
// One item is worked on at a time; the next is taken once its results are out.
// Synchronous active-low reset clears every slot and sets the free-slot hint to slot 0.
`default_nettype none
module timed_task_slot_scheduler #(
    parameter int NUM_SLOTS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // func_id, arg_word, period, now_time, runtime_limit, slot
    input  wire logic [tts_pkg::S_DATA_W-1:0] i_s_tdata,
    // mode
    input  wire logic [1:0]                    i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // slot_index, fired_func, fired_arg, full_res, fire_count, next_due
    output logic [tts_pkg::M_DATA_W-1:0]       o_m_tdata,
    // kind
    output logic [1:0]                         o_m_tuser,
    output logic                               o_m_tlast
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]    r_state;
    logic [IW-1:0] r_step;
    logic [31:0]   r_now;
    logic [31:0]   r_nrt;
    logic [CW-1:0] r_cnt;
    logic          r_hint_valid;
    logic [IW-1:0] r_hint;
    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [tts_pkg::M_DATA_W-1:0] r_odata;
    logic          r_olast;

    tts_pkg::t_slot w_slot [NUM_SLOTS];
    tts_pkg::t_slot w_proc;
    tts_pkg::t_slot w_wdata;
    logic [NUM_SLOTS-1:0] w_wr;
    logic [NUM_SLOTS-1:0] w_busy;

    logic [15:0] in_func;
    logic [31:0] in_arg, in_period, in_now, in_limit;
    logic [3:0]  in_slot;
    assign in_func   = i_s_tdata[15:0];
    assign in_arg    = i_s_tdata[47:16];
    assign in_period = i_s_tdata[79:48];
    assign in_now    = i_s_tdata[111:80];
    assign in_limit  = i_s_tdata[143:112];
    assign in_slot   = i_s_tdata[147:144];

    logic out_free, accept, step_go;
    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign step_go    = (r_state == ST_TICK) && out_free;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            tts_pkg::t_slot w_prev;
            if (g == NUM_SLOTS - 1) begin : g_tail
                assign w_prev = w_proc;
            end else begin : g_mid
                assign w_prev = w_slot[g+1];
            end
            tts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (step_go),
                .i_prev  (w_prev),
                .i_wr    (w_wr[g]),
                .i_wdata (w_wdata),
                .o_slot  (w_slot[g])
            );
            assign w_busy[g] = w_slot[g].busy;
        end
    endgenerate

    // head cell update
    tts_pkg::t_slot head;
    logic [31:0] d0;
    logic        neg, fire;
    logic [31:0] n_nrt_step;
    always_comb begin
        head = w_slot[0];
        neg  = head.period[31];
        if (head.due != '0) begin
            d0 = head.due;
        end else if (head.period == '0) begin
            d0 = r_now;
        end else if (neg) begin
            d0 = 32'd0 - head.period;
        end else begin
            d0 = r_now + head.period;
        end
        fire       = head.busy && (d0 <= r_now);
        n_nrt_step = r_nrt;
        w_proc     = head;
        if (fire) begin
            if (head.period == '0 || neg) begin
                w_proc = '0;
            end else begin
                w_proc.due = d0 + head.period;
            end
        end else if (head.busy) begin
            w_proc.due = d0;
            if (d0 < r_nrt) begin
                n_nrt_step = d0;
            end
        end
    end

    logic          lf_found;
    logic [IW-1:0] lf_idx;
    always_comb begin
        lf_found = 1'b0;
        lf_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!w_busy[i]) begin
                lf_found = 1'b1;
                lf_idx   = IW'(i);
            end
        end
    end

    logic          hint_ok;
    logic [IW-1:0] c_idx;
    logic          dest_ok;
    logic [IW-1:0] d_idx;
    always_comb begin
        hint_ok = 1'b0;
        if (r_hint_valid && (32'(r_hint) < NUM_SLOTS)) begin
            hint_ok = !w_busy[r_hint];
        end
        c_idx   = hint_ok ? r_hint : lf_idx;
        d_idx   = IW'(in_slot);
        dest_ok = 1'b0;
        if (32'(in_slot) < NUM_SLOTS) begin
            dest_ok = w_busy[d_idx];
        end
    end

    always_comb begin
        w_wr    = '0;
        w_wdata = '0;
        if (accept && i_s_tuser == tts_pkg::MODE_CREATE && (hint_ok || lf_found)) begin
            w_wr[c_idx]    = 1'b1;
            w_wdata.busy   = 1'b1;
            w_wdata.func   = in_func;
            w_wdata.arg    = in_arg;
            w_wdata.period = in_period;
        end else if (accept && i_s_tuser == tts_pkg::MODE_DESTROY && dest_ok) begin
            w_wr[d_idx] = 1'b1;
        end
    end

    logic n_ovalid;
    always_comb begin
        n_ovalid = r_ovalid && !i_m_tready;
        if (accept && (i_s_tuser == tts_pkg::MODE_CREATE ||
                       i_s_tuser == tts_pkg::MODE_DESTROY)) begin
            n_ovalid = 1'b1;
        end
        if (step_go && fire) begin
            n_ovalid = 1'b1;
        end
        if ((r_state == ST_SUM) && out_free) begin
            n_ovalid = 1'b1;
        end
    end

    function automatic logic [tts_pkg::M_DATA_W-1:0] pack_out(
        input logic [3:0] idx, input logic [15:0] func, input logic [31:0] arg,
        input logic full, input logic [3:0] cnt, input logic [31:0] nrt);
        pack_out = {7'd0, nrt, cnt, full, arg, func, idx};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_cnt        <= '0;
            r_hint_valid <= 1'b1;
            r_hint       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_s_tuser)
                            tts_pkg::MODE_CREATE: begin
                                r_okind  <= tts_pkg::KIND_CREATE;
                                r_olast  <= 1'b1;
                                if (hint_ok || lf_found) begin
                                    r_hint_valid <= 1'b0;
                                    r_odata <= pack_out(4'(c_idx), '0, '0, 1'b0, '0, '0);
                                end else begin
                                    r_odata <= pack_out('0, '0, '0, 1'b1, '0, '0);
                                end
                            end
                            tts_pkg::MODE_TICK: begin
                                r_now   <= in_now;
                                r_nrt   <= in_limit;
                                r_cnt   <= '0;
                                r_step  <= '0;
                                r_state <= ST_TICK;
                            end
                            tts_pkg::MODE_DESTROY: begin
                                r_okind  <= tts_pkg::KIND_DESTROY;
                                r_olast  <= 1'b1;
                                r_odata  <= pack_out(in_slot, '0, '0, 1'b0, '0, '0);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    if (step_go) begin
                        r_nrt  <= n_nrt_step;
                        r_step <= r_step + 1'b1;
                        if (fire) begin
                            r_cnt    <= r_cnt + 1'b1;
                            r_okind  <= tts_pkg::KIND_FIRE;
                            r_olast  <= 1'b0;
                            r_odata  <= pack_out(4'(r_step), head.func, head.arg,
                                                 1'b0, '0, '0);
                        end
                        if (32'(r_step) == NUM_SLOTS - 1) begin
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    if (out_free) begin
                        r_okind  <= tts_pkg::KIND_DONE;
                        r_olast  <= 1'b1;
                        r_odata  <= pack_out('0, '0, '0, 1'b0, 4'(r_cnt), r_nrt);
                        if (r_cnt != '0) begin
                            r_hint_valid <= lf_found;
                            r_hint       <= lf_idx;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

`ifndef SYNTHESIS
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_tready)
        else $error("item taken during tick");
    a_reply_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_s_tuser == tts_pkg::MODE_CREATE ||
                    i_s_tuser == tts_pkg::MODE_DESTROY)) |=> (o_m_tvalid && o_m_tlast))
        else $error("missing reply");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> (32'(r_step) < NUM_SLOTS))
        else $error("step out of range");
`endif

endmodule
`default_nettype wire
